/* rtl/core/psag_pkg.sv */
// Shared types and constants of the patchify scatter address generator.
// Used by the top level, the controller and the datapath modules.
`default_nettype none

package psag_pkg;

  // Divider lanes: patch row, patch column and grid columns, all over merge_size
  localparam int DIV_LANES = 3;
  localparam int DVD_W     = 12;
  localparam int DVS_W     = 9;

  // Multiplier operand digit handled per cycle by the multiply-accumulate unit
  localparam int DIGIT_W   = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_SIZE = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 8'd7;

  typedef struct packed {
    logic [7:0]  channels;
    logic [7:0]  frames;
    logic [11:0] height;
    logic [11:0] width;
    logic [8:0]  patch_size;
    logic [8:0]  merge_size;
    logic [11:0] grid_rows;
    logic [8:0]  grid_cols;
  } cfg_t;

  // Multiply-accumulate sequence: token, output columns, feature, destination
  typedef enum logic [3:0] {
    OP_TOK0, OP_TOK1, OP_TOK2,
    OP_OC0,  OP_OC1,  OP_OC2,
    OP_FT0,  OP_FT1,  OP_FT2,
    OP_DST
  } mac_op_t;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    logic    mac_start;
    mac_op_t mac_op;
    logic    tok_wb;
    logic    oc_wb;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mac_done;
    logic out_room;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/psag_div.sv */
// Three-lane restoring divider, one quotient bit per cycle.
// Uses psag_pkg for lane count and operand widths.
`default_nettype none

module psag_div (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         start,
  input  wire logic [psag_pkg::DVS_W-1:0]                   divisor,
  input  wire logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVD_W-1:0] dividend,
  output logic      [psag_pkg::DIV_LANES-1:0][psag_pkg::DVD_W-1:0] quot,
  output logic      [psag_pkg::DIV_LANES-1:0][psag_pkg::DVS_W-1:0] rem,
  output logic                                              done
);

  localparam int CntW = $clog2(psag_pkg::DVD_W);

  logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVS_W-1:0] r_r, r_nxt;
  logic [psag_pkg::DVS_W-1:0] dvs_r;
  logic [CntW-1:0]            cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic                       last;

  always_comb begin
    logic [psag_pkg::DVS_W:0] sh;
    logic                     ge;
    q_nxt = q_r;
    r_nxt = r_r;
    for (int i = 0; i < psag_pkg::DIV_LANES; i++) begin
      sh = {r_r[i], q_r[i][psag_pkg::DVD_W-1]};
      ge = sh >= {1'b0, dvs_r};
      r_nxt[i] = ge ? psag_pkg::DVS_W'(sh - {1'b0, dvs_r}) : sh[psag_pkg::DVS_W-1:0];
      q_nxt[i] = {q_r[i][psag_pkg::DVD_W-2:0], ge};
    end
  end

  assign last = cnt_r == CntW'(psag_pkg::DVD_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign quot = q_r;
  assign rem  = r_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/core/psag_mac.sv */
// Digit-serial multiply-accumulate: acc = a*b + c modulo 2^IW, one byte of b per cycle.
// Uses psag_pkg for the digit width.
`default_nettype none

module psag_mac #(
  parameter int IW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [IW-1:0] a,
  input  wire logic [IW-1:0] b,
  input  wire logic [IW-1:0] c,
  output logic      [IW-1:0] acc,
  output logic               done
);

  localparam int DW = psag_pkg::DIGIT_W;

  logic [IW-1:0]    a_r;
  logic [IW-1:0]    b_r;
  logic [IW-1:0]    acc_r;
  logic [IW+DW-1:0] prod;
  logic             busy_r;
  logic             done_r;
  logic             last;

  assign prod = {{DW{1'b0}}, a_r} * {{IW{1'b0}}, b_r[DW-1:0]};
  // Finish once no nonzero digit of b remains above the current one
  assign last = b_r[IW-1:DW] == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= c;
    end else if (busy_r) begin
      a_r   <= a_r << DW;
      b_r   <= b_r >> DW;
      acc_r <= acc_r + prod[IW-1:0];
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/core/psag_dpath.sv */
// Datapath: position counters, divider, multiply-accumulate and output register.
// Uses psag_pkg, psag_div and psag_mac; driven by commands from psag_ctrl.
`default_nettype none

module psag_dpath #(
  parameter int MAX_ROW_WIDTH = 256,
  parameter int INDEX_BITS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire psag_pkg::cfg_t    cfg,
  input  wire psag_pkg::dp_cmd_t cmd,
  output psag_pkg::dp_sts_t      sts,
  input  wire logic [31:0]       in_pixel_word,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   out_write_enable,
  output logic [31:0]            out_dest_index,
  output logic [31:0]            out_pixel_value,
  output logic                   out_tensor_end
);

  localparam int          IW      = INDEX_BITS;
  localparam int          WideW   = (INDEX_BITS > 32) ? INDEX_BITS : 32;
  localparam logic [12:0] MaxRowW = 13'(MAX_ROW_WIDTH);

  // Position counters
  logic [7:0]  chan_r, chan_nxt;
  logic [7:0]  frame_r, frame_nxt;
  logic [11:0] row_r, row_nxt;
  logic [11:0] col_r, col_nxt;
  logic [7:0]  rip_r, rip_nxt;
  logic [11:0] prow_r, prow_nxt;
  logic [7:0]  cip_r, cip_nxt;
  logic [11:0] pcol_r, pcol_nxt;

  logic [31:0]   pix_r;
  logic [IW-1:0] tok_r;
  logic [IW-1:0] oc_r;

  logic        out_valid_r;
  logic        out_we_r;
  logic [31:0] out_dest_r;
  logic [31:0] out_pix_r;
  logic        out_end_r;

  // Divider
  logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVD_W-1:0] dvd;
  logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVD_W-1:0] quot;
  logic [psag_pkg::DIV_LANES-1:0][psag_pkg::DVS_W-1:0] rem;
  logic        div_done;
  logic        mz;
  logic [11:0] bh, bw, bwid;
  logic [8:0]  mh, mw;

  // Multiply-accumulate
  logic [IW-1:0] mac_a, mac_b, mac_c, acc;
  logic          mac_done;

  logic              col_end, row_end, frame_end, chan_end;
  logic              cp_wrap, rp_wrap;
  logic              enabled;
  logic [17:0]       gc_px;
  logic [WideW-1:0]  dest_wide;

  assign dvd[0] = prow_r;
  assign dvd[1] = pcol_r;
  assign dvd[2] = 12'(cfg.grid_cols);

  psag_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (cfg.merge_size),
    .dividend (dvd),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  // A zero merge size yields quotient and remainder of zero
  assign mz   = cfg.merge_size == '0;
  assign bh   = mz ? '0 : quot[0];
  assign mh   = mz ? '0 : rem[0];
  assign bw   = mz ? '0 : quot[1];
  assign mw   = mz ? '0 : rem[1];
  assign bwid = mz ? '0 : quot[2];

  // Chained steps take the previous product straight from the accumulator
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    unique case (cmd.mac_op)
      psag_pkg::OP_TOK0: begin
        mac_a = IW'(bh);
        mac_b = IW'(bwid);
        mac_c = IW'(bw);
      end
      psag_pkg::OP_TOK1: begin
        mac_a = acc;
        mac_b = IW'(cfg.merge_size);
        mac_c = IW'(mh);
      end
      psag_pkg::OP_TOK2: begin
        mac_a = acc;
        mac_b = IW'(cfg.merge_size);
        mac_c = IW'(mw);
      end
      psag_pkg::OP_OC0: begin
        mac_a = IW'(cfg.channels);
        mac_b = IW'(cfg.frames);
      end
      psag_pkg::OP_OC1, psag_pkg::OP_OC2: begin
        mac_a = acc;
        mac_b = IW'(cfg.patch_size);
      end
      psag_pkg::OP_FT0: begin
        mac_a = IW'(chan_r);
        mac_b = IW'(cfg.frames);
        mac_c = IW'(frame_r);
      end
      psag_pkg::OP_FT1: begin
        mac_a = acc;
        mac_b = IW'(cfg.patch_size);
        mac_c = IW'(rip_r);
      end
      psag_pkg::OP_FT2: begin
        mac_a = acc;
        mac_b = IW'(cfg.patch_size);
        mac_c = IW'(cip_r);
      end
      psag_pkg::OP_DST: begin
        mac_a = tok_r;
        mac_b = oc_r;
        mac_c = acc;
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  psag_mac #(.IW(IW)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .c     (mac_c),
    .acc   (acc),
    .done  (mac_done)
  );

  // End-of-dimension flags
  assign col_end   = ({1'b0, col_r} + 13'd1) >= {1'b0, cfg.width};
  assign row_end   = ({1'b0, row_r} + 13'd1) >= {1'b0, cfg.height};
  assign frame_end = ({1'b0, frame_r} + 9'd1) >= {1'b0, cfg.frames};
  assign chan_end  = ({1'b0, chan_r} + 9'd1) >= {1'b0, cfg.channels};
  assign cp_wrap   = ({1'b0, cip_r} + 9'd1) >= cfg.patch_size;
  assign rp_wrap   = ({1'b0, rip_r} + 9'd1) >= cfg.patch_size;

  always_comb begin
    chan_nxt  = chan_r;
    frame_nxt = frame_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rip_nxt   = rip_r;
    prow_nxt  = prow_r;
    cip_nxt   = cip_r;
    pcol_nxt  = pcol_r;
    if (!col_end) begin
      col_nxt = col_r + 12'd1;
      if (cp_wrap) begin
        cip_nxt  = '0;
        pcol_nxt = pcol_r + 12'd1;
      end else begin
        cip_nxt = cip_r + 8'd1;
      end
    end else begin
      col_nxt  = '0;
      cip_nxt  = '0;
      pcol_nxt = '0;
      if (!row_end) begin
        row_nxt = row_r + 12'd1;
        if (rp_wrap) begin
          rip_nxt  = '0;
          prow_nxt = prow_r + 12'd1;
        end else begin
          rip_nxt = rip_r + 8'd1;
        end
      end else begin
        row_nxt  = '0;
        rip_nxt  = '0;
        prow_nxt = '0;
        if (!frame_end) begin
          frame_nxt = frame_r + 8'd1;
        end else begin
          frame_nxt = '0;
          chan_nxt  = chan_end ? '0 : chan_r + 8'd1;
        end
      end
    end
  end

  assign gc_px   = 18'(cfg.grid_cols) * 18'(cfg.patch_size);
  assign enabled = (cfg.channels != '0) && (cfg.frames != '0) && (cfg.height != '0)
                && (cfg.width != '0) && (cfg.patch_size != '0) && (cfg.merge_size != '0)
                && (cfg.grid_rows != '0) && (cfg.grid_cols != '0)
                && ({1'b0, cfg.width} <= MaxRowW) && (18'(col_r) < gc_px);

  assign dest_wide = WideW'(acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      frame_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      rip_r       <= '0;
      prow_r      <= '0;
      cip_r       <= '0;
      pcol_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        chan_r      <= chan_nxt;
        frame_r     <= frame_nxt;
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        rip_r       <= rip_nxt;
        prow_r      <= prow_nxt;
        cip_r       <= cip_nxt;
        pcol_r      <= pcol_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_pixel_word;
    end
    if (cmd.tok_wb) begin
      tok_r <= acc;
    end
    if (cmd.oc_wb) begin
      oc_r <= acc;
    end
    if (cmd.out_load) begin
      out_we_r   <= enabled;
      out_dest_r <= dest_wide[31:0];
      out_pix_r  <= pix_r;
      out_end_r  <= col_end && row_end && frame_end && chan_end;
    end
  end

  assign sts.div_done = div_done;
  assign sts.mac_done = mac_done;
  assign sts.out_room = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_dest_index   = out_dest_r;
  assign out_pixel_value  = out_pix_r;
  assign out_tensor_end   = out_end_r;

endmodule

`default_nettype wire

/* rtl/core/psag_ctrl.sv */
// Controller: sequences capture, division, the multiply-accumulate chain and output load.
// Uses psag_pkg for the command, status and operation types.
`default_nettype none

module psag_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output psag_pkg::dp_cmd_t      cmd,
  input  wire psag_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MAC, S_OUT} state_t;

  state_t            state_r, state_nxt;
  psag_pkg::mac_op_t op_r, op_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd        = '0;
    cmd.mac_op = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture   = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          op_nxt        = psag_pkg::OP_TOK0;
          cmd.mac_op    = psag_pkg::OP_TOK0;
          cmd.mac_start = 1'b1;
          state_nxt     = S_MAC;
        end
      end
      S_MAC: begin
        if (sts.mac_done) begin
          cmd.tok_wb = op_r == psag_pkg::OP_TOK2;
          cmd.oc_wb  = op_r == psag_pkg::OP_OC2;
          if (op_r == psag_pkg::OP_DST) begin
            state_nxt = S_OUT;
          end else begin
            // advance to the next product of the chain
            op_nxt        = psag_pkg::mac_op_t'(op_r + 4'd1);
            cmd.mac_op    = op_nxt;
            cmd.mac_start = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (sts.out_room) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= psag_pkg::OP_TOK0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

`default_nettype wire

/* rtl/core/patchify_scatter_address_gen.sv */
// Top level of the patchify scatter address generator: configuration registers,
// controller and datapath. Depends on psag_pkg, psag_ctrl and psag_dpath.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_pixel_word
//   out_     output     out_valid/out_stall out_write_enable, out_dest_index,
//                                           out_pixel_value, out_tensor_end
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One item at a time: the item is accepted, divided, put through ten multiply-accumulate
// steps, each running over the significant bytes of the multiplier operand, and then
// loaded into the output register once the controller sees the last step end.
// Reset is synchronous; counters restart at zero and configuration registers take their defaults.
// A new item is taken while the previous result still waits in the output register;
// a stalled output only holds the controller when the next result is ready.
`default_nettype none

module patchify_scatter_address_gen #(
  parameter int MAX_ROW_WIDTH = 256,
  parameter int INDEX_BITS    = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      in_pixel_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_write_enable,
  output logic [31:0]                           out_dest_index,
  output logic [31:0]                           out_pixel_value,
  output logic                                  out_tensor_end,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [psag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psag_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  psag_pkg::cfg_t    cfg_r;
  psag_pkg::dp_cmd_t cmd;
  psag_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels   <= 8'd1;
      cfg_r.frames     <= 8'd1;
      cfg_r.height     <= 12'd256;
      cfg_r.width      <= 12'd256;
      cfg_r.patch_size <= 9'd16;
      cfg_r.merge_size <= 9'd2;
      cfg_r.grid_rows  <= 12'd16;
      cfg_r.grid_cols  <= 9'd16;
    end else if (cfg_valid) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_index)
        psag_pkg::REG_CHANNELS:   cfg_r.channels   <= cfg_wdata[7:0];
        psag_pkg::REG_FRAMES:     cfg_r.frames     <= cfg_wdata[7:0];
        psag_pkg::REG_HEIGHT:     cfg_r.height     <= cfg_wdata[11:0];
        psag_pkg::REG_WIDTH:      cfg_r.width      <= cfg_wdata[11:0];
        psag_pkg::REG_PATCH_SIZE: cfg_r.patch_size <= cfg_wdata[8:0];
        psag_pkg::REG_MERGE_SIZE: cfg_r.merge_size <= cfg_wdata[8:0];
        psag_pkg::REG_GRID_ROWS:  cfg_r.grid_rows  <= cfg_wdata[11:0];
        psag_pkg::REG_GRID_COLS:  cfg_r.grid_cols  <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  psag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  psag_dpath #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .INDEX_BITS    (INDEX_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_pixel_word    (in_pixel_word),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_index   (out_dest_index),
    .out_pixel_value  (out_pixel_value),
    .out_tensor_end   (out_tensor_end)
  );

endmodule

`default_nettype wire
